// ===== design/otst_pkg.sv =====
// ----------------------------------------------------------------------------
// otst_pkg
// Shared types and constants for the one-shot timer slot table.
// ----------------------------------------------------------------------------
package otst_pkg;

  localparam int NOW_W       = 64;
  localparam int DELAY_W     = 32;
  localparam int HANDLE_W    = 8;
  localparam int SLOT_W      = 3;
  localparam int KIND_W      = 2;
  localparam int IN_DATA_W   = NOW_W + DELAY_W + HANDLE_W;
  localparam int OUT_DATA_W  = 16;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_CMP
  } alu_mode_t;

  // Commands from the sequencer to the slot store.
  typedef struct packed {
    logic alloc;   // claim the lowest free slot and write it
    logic retire;  // free the slot at the read index
  } store_cmd_t;

endpackage

// ===== design/otst_alu.sv =====
// ----------------------------------------------------------------------------
// otst_alu
// Shared 64-bit adder: forms wake times and compares wake times with now.
// ----------------------------------------------------------------------------
module otst_alu (
  input  otst_pkg::alu_mode_t           mode,
  input  logic [otst_pkg::NOW_W-1:0]    a,
  input  logic [otst_pkg::NOW_W-1:0]    b,
  output logic [otst_pkg::NOW_W-1:0]    sum,
  output logic                          carry
);

  logic [otst_pkg::NOW_W-1:0] b_op;
  logic                       cin;

  // In compare mode the adder works out a - b; a carry out means a >= b.
  always_comb begin
    unique case (mode)
      otst_pkg::ALU_ADD: begin
        b_op = b;
        cin  = 1'b0;
      end
      otst_pkg::ALU_CMP: begin
        b_op = ~b;
        cin  = 1'b1;
      end
      default: begin
        b_op = b;
        cin  = 1'b0;
      end
    endcase
  end

  assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{otst_pkg::NOW_W{1'b0}}, cin};

endmodule

// ===== design/otst_store.sv =====
// ----------------------------------------------------------------------------
// otst_store
// Slot storage: occupancy flags, wake times and handles, with a lowest-free
// slot finder.
// ----------------------------------------------------------------------------
module otst_store #(
  parameter int SLOTS       = 8,
  parameter int HANDLE_BITS = 8,
  parameter int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  otst_pkg::store_cmd_t          cmd,
  input  logic [otst_pkg::NOW_W-1:0]    wr_wake,
  input  logic [HANDLE_BITS-1:0]        wr_handle,
  input  logic [IDX_W-1:0]              rd_idx,
  output logic                          rd_busy,
  output logic [otst_pkg::NOW_W-1:0]    rd_wake,
  output logic [HANDLE_BITS-1:0]        rd_handle,
  output logic                          free_found,
  output logic [IDX_W-1:0]              free_idx
);

  logic [SLOTS-1:0]             busy;
  logic [otst_pkg::NOW_W-1:0]   wake [SLOTS];
  logic [HANDLE_BITS-1:0]       hnd  [SLOTS];

  // Lowest free slot wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      if (cmd.alloc && free_found) begin
        busy[free_idx] <= 1'b1;
      end
      if (cmd.retire) begin
        busy[rd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc && free_found) begin
      wake[free_idx] <= wr_wake;
      hnd[free_idx]  <= wr_handle;
    end
  end

  assign rd_busy   = busy[rd_idx];
  assign rd_wake   = wake[rd_idx];
  assign rd_handle = hnd[rd_idx];

endmodule

// ===== design/one_shot_timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_slot_table
// A table of SLOTS one-shot timers. An add word (tuser 0) carries the current
// time, a delay and a handle; it claims the lowest free slot, stores the
// handle with a wake time of now plus delay (wrapping at 64 bits) and answers
// accepted with the slot number, or rejected when the table is full. A tick
// word (tuser 1) carries the current time; every busy slot whose wake time is
// at or below it fires in ascending slot order, at most eight per tick, each
// giving one fired word with slot and handle and freeing the slot. A tick that
// fires nothing gives a single none word. tlast marks the final result word
// of each input word. The block takes one input word at a time: an add is
// held in the ADD state until its result is loaded, and a tick in the SCAN
// and FINISH states, the scan ending at the last slot or early at the eighth
// firing. The single shared 64-bit adder compares one slot per cycle; a due
// slot waits while the held-back firing cannot go to the output register.
// Until the last result word is loaded into the output register, s_tready
// stays low.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_table #(
  parameter int SLOTS       = 8,
  parameter int HANDLE_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input words.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [otst_pkg::IN_DATA_W-1:0]     s_tdata,  // now_time[63:0], delay[95:64],
                                                       // handle[103:96]
  input  logic                               s_tuser,  // op
  // Result words.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [otst_pkg::OUT_DATA_W-1:0]    m_tdata,  // slot[2:0], fired_handle[10:3],
                                                       // zero padding above
  output logic [otst_pkg::KIND_W-1:0]        m_tuser,  // kind
  output logic                               m_tlast   // last
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_XW = (IDX_W > otst_pkg::SLOT_W) ? IDX_W : otst_pkg::SLOT_W;
  localparam int HND_XW  = (HANDLE_BITS > otst_pkg::HANDLE_W) ? HANDLE_BITS
                                                              : otst_pkg::HANDLE_W;

  // Sequencer state.
  otst_pkg::state_t                 state, state_next;
  logic [IDX_W-1:0]                 idx, idx_next;
  logic [otst_pkg::CNT_W-1:0]       cnt, cnt_next;

  // Latched input word.
  logic [otst_pkg::NOW_W-1:0]       cur_now;
  logic [otst_pkg::DELAY_W-1:0]     cur_delay;
  logic [otst_pkg::HANDLE_W-1:0]    cur_handle;

  // A fired slot is held back one step, since whether it is the last result
  // is known only once the next firing is found or the scan ends.
  logic                             pend_valid, pend_valid_next;
  logic [IDX_W-1:0]                 pend_slot, pend_slot_next;
  logic [otst_pkg::HANDLE_W-1:0]    pend_handle, pend_handle_next;

  // Result loading.
  logic                             out_free;
  logic                             emit;
  otst_pkg::kind_t                  emit_kind;
  logic [IDX_W-1:0]                 emit_slot;
  logic [otst_pkg::HANDLE_W-1:0]    emit_handle;
  logic                             emit_last;
  logic [SLOT_XW-1:0]               emit_slot_x;

  // Store and adder connections.
  otst_pkg::store_cmd_t             cmd;
  otst_pkg::alu_mode_t              alu_mode;
  logic [otst_pkg::NOW_W-1:0]       alu_b;
  logic [otst_pkg::NOW_W-1:0]       alu_sum;
  logic                             alu_carry;
  logic                             rd_busy;
  logic [otst_pkg::NOW_W-1:0]       rd_wake;
  logic [HANDLE_BITS-1:0]           rd_handle;
  logic                             free_found;
  logic [IDX_W-1:0]                 free_idx;
  logic [HND_XW-1:0]                in_handle_x;
  logic [HND_XW-1:0]                rd_handle_x;
  logic [HANDLE_BITS-1:0]           wr_handle;
  logic [otst_pkg::HANDLE_W-1:0]    rd_handle8;
  logic                             due;
  logic                             take;

  // Handles are stored at HANDLE_BITS and shown at the port width.
  assign in_handle_x = HND_XW'(cur_handle);
  assign wr_handle   = in_handle_x[HANDLE_BITS-1:0];
  assign rd_handle_x = HND_XW'(rd_handle);
  assign rd_handle8  = rd_handle_x[otst_pkg::HANDLE_W-1:0];

  // The adder forms now + delay for an add, and now - wake during a scan.
  assign alu_mode = (state == otst_pkg::ST_ADD) ? otst_pkg::ALU_ADD : otst_pkg::ALU_CMP;
  assign alu_b    = (state == otst_pkg::ST_ADD) ? otst_pkg::NOW_W'(cur_delay) : rd_wake;

  otst_alu u_alu (
    .mode  (alu_mode),
    .a     (cur_now),
    .b     (alu_b),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  otst_store #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .wr_wake    (alu_sum),
    .wr_handle  (wr_handle),
    .rd_idx     (idx),
    .rd_busy    (rd_busy),
    .rd_wake    (rd_wake),
    .rd_handle  (rd_handle),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  assign s_tready = (state == otst_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // A carry out of now - wake means the wake time is at or below now.
  assign due = rd_busy && alu_carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= otst_pkg::ST_IDLE;
      idx        <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot   <= pend_slot_next;
    pend_handle <= pend_handle_next;
    if (s_tvalid && s_tready) begin
      cur_now    <= s_tdata[otst_pkg::NOW_W-1:0];
      cur_delay  <= s_tdata[otst_pkg::NOW_W +: otst_pkg::DELAY_W];
      cur_handle <= s_tdata[otst_pkg::NOW_W + otst_pkg::DELAY_W +: otst_pkg::HANDLE_W];
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    cnt_next         = cnt;
    pend_valid_next  = pend_valid;
    pend_slot_next   = pend_slot;
    pend_handle_next = pend_handle;
    emit             = 1'b0;
    emit_kind        = otst_pkg::KIND_NONE;
    emit_slot        = '0;
    emit_handle      = '0;
    emit_last        = 1'b0;
    cmd              = '0;
    take             = 1'b0;

    unique case (state)
      otst_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next      = (s_tuser == otst_pkg::OP_TICK) ? otst_pkg::ST_SCAN
                                                           : otst_pkg::ST_ADD;
          idx_next        = '0;
          cnt_next        = '0;
          pend_valid_next = 1'b0;
        end
      end

      otst_pkg::ST_ADD: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          if (free_found) begin
            emit_kind = otst_pkg::KIND_ACCEPTED;
            emit_slot = free_idx;
            cmd.alloc = 1'b1;
          end else begin
            emit_kind = otst_pkg::KIND_REJECTED;
          end
          state_next = otst_pkg::ST_IDLE;
        end
      end

      otst_pkg::ST_SCAN: begin
        // A due slot is taken once the held-back firing can be sent on.
        take = due && (!pend_valid || out_free);
        if (take) begin
          if (pend_valid) begin
            emit        = 1'b1;
            emit_kind   = otst_pkg::KIND_FIRED;
            emit_slot   = pend_slot;
            emit_handle = pend_handle;
          end
          cmd.retire       = 1'b1;
          pend_valid_next  = 1'b1;
          pend_slot_next   = idx;
          pend_handle_next = rd_handle8;
          cnt_next         = cnt + otst_pkg::CNT_W'(1);
        end
        if (!due || take) begin
          if ((idx == IDX_W'(SLOTS - 1)) ||
              (take && (cnt == otst_pkg::CNT_W'(otst_pkg::MAX_RESULTS - 1)))) begin
            state_next = otst_pkg::ST_FINISH;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end

      otst_pkg::ST_FINISH: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (pend_valid) begin
            emit_kind   = otst_pkg::KIND_FIRED;
            emit_slot   = pend_slot;
            emit_handle = pend_handle;
          end
          pend_valid_next = 1'b0;
          state_next      = otst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = otst_pkg::ST_IDLE;
      end
    endcase
  end

  assign emit_slot_x = SLOT_XW'(emit_slot);

  // Output register: loaded only when empty or being drained this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= otst_pkg::OUT_DATA_W'({emit_handle, emit_slot_x[otst_pkg::SLOT_W-1:0]});
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
    end
  end

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result loaded while the output register was still full");

  // No tick fires more than the permitted number of slots.
  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= otst_pkg::CNT_W'(otst_pkg::MAX_RESULTS))
    else $error("tick fired too many slots");

  // Once a word is taken, the block works on it before taking another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a previous word was still in work");

  // The scan never frees a slot that is not due.
  a_retire_due: assert property (@(posedge clk) disable iff (rst)
    cmd.retire |-> (state == otst_pkg::ST_SCAN) && due)
    else $error("slot freed without being due");

endmodule

// ===== bench/tb_one_shot_timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// tb_one_shot_timer_slot_table
// Self-checking bench for the one-shot timer slot table. A clocked driver
// sends add and tick words from a queue. An internal copy of the slot table
// predicts every result word. A clocked monitor checks each result word,
// field by field, against the oldest prediction. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_one_shot_timer_slot_table;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 225;

  // One input word as the driver sends it. The gap is the idle time that
  // follows the word once it has been taken. A word marked drain_first is
  // held back until every outstanding result has come out of the block.
  typedef struct {
    logic                           op;
    logic [otst_pkg::NOW_W-1:0]     now_time;
    logic [otst_pkg::DELAY_W-1:0]   delay;
    logic [otst_pkg::HANDLE_W-1:0]  handle;
    int                             gap;
    bit                             drain_first;
  } timer_word_t;

  // One result word as the slot table should produce it.
  typedef struct {
    otst_pkg::kind_t                kind;
    logic [otst_pkg::SLOT_W-1:0]    slot;
    logic [otst_pkg::HANDLE_W-1:0]  fired_handle;
    logic                           last;
  } timer_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [otst_pkg::IN_DATA_W-1:0]   s_tdata = '0;
  logic                             s_tuser = otst_pkg::OP_ADD;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [otst_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic [otst_pkg::KIND_W-1:0]      m_tuser;
  logic                             m_tlast;

  // Words waiting to be sent, and results predicted but not yet seen.
  timer_word_t            timer_words[$];
  timer_result_t          timer_results[$];

  // The bench's own copy of the slot table. It is cleared once, matching the
  // single reset at the start of the run.
  bit                             slot_busy[SLOTS] = '{default: 1'b0};
  logic [otst_pkg::NOW_W-1:0]     wake_time[SLOTS];
  logic [otst_pkg::HANDLE_W-1:0]  slot_handle[SLOTS];

  timer_word_t            on_bus;
  int                     words_loaded = 0;
  int                     results_paced = 0;
  int                     gap_left = 0;
  int                     stall_left = 0;
  int                     cycle_count = 0;
  int                     mismatches = 0;
  int                     words_sent = 0;
  int                     results_seen = 0;
  int                     adds_accepted = 0;
  int                     adds_rejected = 0;
  int                     timers_fired = 0;
  int                     idle_ticks = 0;

  one_shot_timer_slot_table #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (otst_pkg::HANDLE_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void push_word(input logic op,
                                    input logic [otst_pkg::NOW_W-1:0] now_time,
                                    input logic [otst_pkg::DELAY_W-1:0] delay,
                                    input logic [otst_pkg::HANDLE_W-1:0] handle,
                                    input int gap, input bit drain_first);
    timer_word_t w;
    w.op          = op;
    w.now_time    = now_time;
    w.delay       = delay;
    w.handle      = handle;
    w.gap         = gap;
    w.drain_first = drain_first;
    timer_words.push_back(w);
  endfunction

  // Updates the slot table copy for one accepted word and queues the result
  // words that it must produce.
  task automatic apply_timer_word(input timer_word_t w);
    timer_result_t r;
    bit            placed;
    int            due;
    int            n;
    r.kind         = otst_pkg::KIND_REJECTED;
    r.slot         = '0;
    r.fired_handle = '0;
    r.last         = 1'b1;
    placed         = 1'b0;
    due            = 0;
    n              = 0;
    if (w.op == otst_pkg::OP_ADD) begin
      // The lowest free slot is claimed; a full table leaves everything alone.
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !slot_busy[i]) begin
          placed         = 1'b1;
          slot_busy[i]   = 1'b1;
          slot_handle[i] = w.handle;
          wake_time[i]   = w.now_time + otst_pkg::NOW_W'(w.delay);
          r.kind         = otst_pkg::KIND_ACCEPTED;
          r.slot         = otst_pkg::SLOT_W'(i);
        end
      end
      timer_results.push_back(r);
    end else begin
      // Count the due slots first so that the final firing carries last.
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i] && wake_time[i] <= w.now_time && due < otst_pkg::MAX_RESULTS) begin
          due++;
        end
      end
      if (due == 0) begin
        r.kind = otst_pkg::KIND_NONE;
        timer_results.push_back(r);
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (n < due && slot_busy[i] && wake_time[i] <= w.now_time) begin
            r.kind         = otst_pkg::KIND_FIRED;
            r.slot         = otst_pkg::SLOT_W'(i);
            r.fired_handle = slot_handle[i];
            r.last         = (n == due - 1);
            slot_busy[i]   = 1'b0;
            timer_results.push_back(r);
            n++;
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: %s mismatch, got 0x%0h, wanted 0x%0h", $time, what, got, want);
    end
  endtask

  // Input side. The bus is only reloaded once the current word has been
  // taken, so tvalid stays high across back-to-back words with no gap.
  always @(negedge clk) begin : word_driver
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= otst_pkg::OP_ADD;
    end else if (!s_tvalid || words_sent == words_loaded) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (timer_words.size() != 0 &&
                   !(timer_words[0].drain_first && timer_results.size() != 0)) begin
        on_bus   = timer_words.pop_front();
        gap_left = on_bus.gap;
        words_loaded++;
        s_tvalid <= 1'b1;
        s_tdata  <= {on_bus.handle, on_bus.delay, on_bus.now_time};
        s_tuser  <= on_bus.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side. Each result word draws its own stall, which only counts
  // down while a word is on offer; every fourth stretch of results runs
  // with no stall at all.
  always @(negedge clk) begin : result_acceptor
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (results_paced != results_seen) begin
        results_paced = results_seen;
        stall_left    = ((results_seen / 32) % 4 == 3) ? 0 : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        if (m_tvalid) begin
          stall_left--;
        end
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Everything sampled at the rising edge: the timeout, result checking and
  // the prediction for a word taken at this edge. Results are checked first,
  // since a word taken now cannot have produced anything yet.
  always @(posedge clk) begin : edge_monitor
    timer_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, timer_results.size());
      $display("tb_one_shot_timer_slot_table failed");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (timer_results.size() == 0) begin
          report_mismatch("unexpected result word", 64'({m_tuser, m_tdata}), '0);
        end else begin
          want = timer_results.pop_front();
          case (want.kind)
            otst_pkg::KIND_ACCEPTED: adds_accepted++;
            otst_pkg::KIND_REJECTED: adds_rejected++;
            otst_pkg::KIND_FIRED:    timers_fired++;
            default:                 idle_ticks++;
          endcase
          if (m_tuser !== want.kind) begin
            report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
          end
          if (m_tdata[otst_pkg::SLOT_W-1:0] !== want.slot) begin
            report_mismatch("slot", 64'(m_tdata[otst_pkg::SLOT_W-1:0]), 64'(want.slot));
          end
          if (m_tdata[otst_pkg::SLOT_W +: otst_pkg::HANDLE_W] !== want.fired_handle) begin
            report_mismatch("fired handle",
                            64'(m_tdata[otst_pkg::SLOT_W +: otst_pkg::HANDLE_W]),
                            64'(want.fired_handle));
          end
          if (m_tlast !== want.last) begin
            report_mismatch("last", 64'(m_tlast), 64'(want.last));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_timer_word(on_bus);
        words_sent++;
      end
    end
  end

  initial begin : stimulus
    logic [otst_pkg::NOW_W-1:0] t_now;
    int                         add_pct;
    int                         roll;
    int                         gap;

    // Directed part. A tick on an empty table gives a single none word.
    push_word(otst_pkg::OP_TICK, 64'd0, 32'd0, 8'd0, $urandom_range(0, 6), 1'b0);
    // Fill the table. The first add wraps its wake time round to zero, the
    // second uses the largest delay, the third a zero delay and the fourth
    // sits in the upper half of the time range.
    push_word(otst_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 8'h00,
              $urandom_range(0, 6), 1'b0);
    push_word(otst_pkg::OP_ADD, 64'd0, 32'hFFFF_FFFF, 8'hFF, $urandom_range(0, 6), 1'b0);
    push_word(otst_pkg::OP_ADD, 64'd100, 32'd0, 8'hA5, $urandom_range(0, 6), 1'b0);
    push_word(otst_pkg::OP_ADD, 64'h8000_0000_0000_0000, 32'd5, 8'h5A,
              $urandom_range(0, 6), 1'b0);
    for (int i = 1; i <= 4; i++) begin
      push_word(otst_pkg::OP_ADD, 64'd200, 32'(i * 10), 8'(i), $urandom_range(0, 6), 1'b0);
    end
    // With every slot busy the next add is turned away.
    push_word(otst_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
              $urandom_range(0, 6), 1'b0);
    // The wrapped timer fires at time zero; one tick short of a wake time
    // fires nothing, and a tick exactly on it fires.
    push_word(otst_pkg::OP_TICK, 64'd0, 32'd0, 8'd0, $urandom_range(0, 6), 1'b0);
    push_word(otst_pkg::OP_TICK, 64'd99, 32'hFFFF_FFFF, 8'hFF, $urandom_range(0, 6), 1'b0);
    push_word(otst_pkg::OP_TICK, 64'd100, 32'd0, 8'd0, $urandom_range(0, 6), 1'b0);
    // A freed low slot is claimed again before any higher one.
    push_word(otst_pkg::OP_ADD, 64'd0, 32'd0, 8'h33, $urandom_range(0, 6), 1'b0);
    // A tick at the top of the time range empties the table in one burst.
    push_word(otst_pkg::OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'd0,
              $urandom_range(0, 6), 1'b0);
    // Refill after the block has drained completely, then fire all eight
    // slots from a single tick.
    for (int i = 0; i < SLOTS; i++) begin
      push_word(otst_pkg::OP_ADD, 64'd0, 32'(i * 3), 8'($urandom), $urandom_range(0, 6),
                i == 0);
    end
    push_word(otst_pkg::OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'd0,
              $urandom_range(0, 6), 1'b0);

    // Random part. Most words follow a time base that moves forward, so that
    // adds fill the table and ticks see slots fall due; phases alternate
    // between add-heavy and tick-heavy traffic. A few words are noise with
    // fully random fields, and one stretch runs across the wrap of time.
    t_now   = 64'($urandom_range(0, 1000));
    add_pct = 70;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 50 == 0) begin
        add_pct = ((k / 50) % 2 == 0) ? 70 : 30;
      end
      if (k == 150) begin
        t_now = 64'hFFFF_FFFF_FFFF_FF00;
      end
      gap  = ((k / 40) % 3 == 2) ? 0 : $urandom_range(0, 6);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        push_word(1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom, 8'($urandom),
                  gap, k % 60 == 59);
      end else if (roll < 8 + (add_pct * 92) / 100) begin
        t_now += 64'($urandom_range(0, 10));
        push_word(otst_pkg::OP_ADD, t_now,
                  ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 300)),
                  8'($urandom), gap, k % 60 == 59);
      end else begin
        t_now += 64'($urandom_range(0, 120));
        push_word(otst_pkg::OP_TICK, t_now, $urandom, 8'($urandom), gap, k % 60 == 59);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (timer_words.size() != 0 || s_tvalid || timer_results.size() != 0) begin
      @(posedge clk);
    end
    // Anything that comes out after this point has no prediction behind it.
    repeat (SLOTS + 20) @(posedge clk);

    $display("Sent %0d words and checked %0d results: %0d adds taken, %0d turned away,",
             words_sent, results_seen, adds_accepted, adds_rejected);
    $display("%0d timers fired and %0d ticks found nothing due; %0d mismatches.",
             timers_fired, idle_ticks, mismatches);
    if (mismatches == 0) begin
      $display("tb_one_shot_timer_slot_table passed");
    end else begin
      $display("tb_one_shot_timer_slot_table failed");
    end
    $finish;
  end

endmodule
